>>> rtl/gep_pkg.sv
`default_nettype none
package gep_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_UPDATED  = 2'd0,
    ST_FROZEN   = 2'd1,
    ST_CAPTURED = 2'd2
  } status_e;

  // Configuration register indexes
  localparam logic [2:0] CFG_HOLE_X      = 3'd0;
  localparam logic [2:0] CFG_HOLE_Y      = 3'd1;
  localparam logic [2:0] CFG_HOLE_RADIUS = 3'd2;
  localparam logic [2:0] CFG_ATTRACTION  = 3'd3;

  localparam logic [31:0] HOLE_X_RST      = 32'd26214400;
  localparam logic [31:0] HOLE_Y_RST      = 32'd19660800;
  localparam logic [31:0] HOLE_RADIUS_RST = 32'd655360;
  localparam logic [47:0] ATTRACTION_RST  = 48'd0;

  localparam logic [23:0] FROZEN_MASS_RAW    = 24'd256000;
  localparam logic [49:0] SOFTEN_Q16         = 50'd655360;
  localparam logic [32:0] CAPTURE_MARGIN_Q16 = 33'd1310720;
  localparam logic [16:0] UNIT_ONE           = 17'd65536;

  // Iteration counts: square root bits, accel quotient bits, direction bits
  localparam int unsigned SQ_STEPS = 32;
  localparam int unsigned DV_STEPS = 45;
  localparam int unsigned UX_STEPS = 17;
  // Accept edge to strobe: 6 front stages, divider, setup, direction, 2 tail
  localparam int unsigned LATENCY  = 6 + DV_STEPS + 1 + UX_STEPS + 2;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [23:0]        particle_mass;
    logic [15:0]        time_step;
  } part_in_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    status_e            status;
  } part_out_t;

  // Per-particle values that ride along the pipeline
  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [15:0] dt;
    logic        frozen;
    logic [31:0] nx;
    logic [31:0] ny;
    logic        neg_x;
    logic        neg_y;
    logic [31:0] ax;
    logic [31:0] ay;
  } carry_t;

  // Square root and acceleration divider state
  typedef struct packed {
    logic        hi;
    logic [63:0] sq_n;
    logic [34:0] sq_rem;
    logic [31:0] sq_root;
    logic [49:0] den;
    logic [50:0] dv_rem;
    logic [44:0] dv_bits;
    logic [44:0] dv_q;
  } iter_t;

  // Unit direction divider state
  typedef struct packed {
    logic [32:0] span;
    logic        zero;
    logic        captured;
    logic [44:0] mag;
    logic        over_x;
    logic        over_y;
    logic [32:0] rx;
    logic [32:0] ry;
    logic [16:0] bx;
    logic [16:0] by;
    logic [16:0] qx;
    logic [16:0] qy;
  } udiv_t;

endpackage
`default_nettype wire

>>> rtl/gravity_euler_particle_step_top.sv
`default_nettype none
// Channel     | Direction | Handshake                   | Payload
// ------------+-----------+-----------------------------+---------------------------
// particle    | in        | start & !busy               | particle_i (part_in_t)
// result      | out       | strobe_o, one cycle         | result_o (part_out_t)
// config      | in        | cfg_valid_i & cfg_ready_o   | cfg_index_i, cfg_data_i
//
// One particle per cycle; result_o is valid in each cycle in which strobe_o is high.
// Latency is set by the 45-step restoring divider for the acceleration
// (one quotient bit per stage) plus the 17-step direction divider.
// busy stays low: the pipeline never stalls, since the receiver cannot.
// Reset clears valid bits and loads the attractor registers; no clearing pass.
module gravity_euler_particle_step_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire gep_pkg::part_in_t  particle_i,
  output logic                    strobe_o,
  output gep_pkg::part_out_t      result_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [47:0]        cfg_data_i
);

  function automatic logic [31:0] sat34(logic [33:0] s);
    if (s[33:31] == 3'b000 || s[33:31] == 3'b111) return s[31:0];
    return s[33] ? 32'h8000_0000 : 32'h7fff_ffff;
  endfunction

  function automatic logic [31:0] sat48(logic [47:0] s);
    if ((&s[47:31]) || !(|s[47:31])) return s[31:0];
    return s[47] ? 32'h8000_0000 : 32'h7fff_ffff;
  endfunction

  function automatic logic [31:0] abs32(logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  // Configuration registers
  logic [31:0] hole_x_q, hole_y_q, hole_radius_q;
  logic [47:0] attraction_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hole_x_q      <= gep_pkg::HOLE_X_RST;
      hole_y_q      <= gep_pkg::HOLE_Y_RST;
      hole_radius_q <= gep_pkg::HOLE_RADIUS_RST;
      attraction_q  <= gep_pkg::ATTRACTION_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        gep_pkg::CFG_HOLE_X:      hole_x_q      <= cfg_data_i[31:0];
        gep_pkg::CFG_HOLE_Y:      hole_y_q      <= cfg_data_i[31:0];
        gep_pkg::CFG_HOLE_RADIUS: hole_radius_q <= cfg_data_i[31:0];
        gep_pkg::CFG_ATTRACTION:  attraction_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic accept;
  assign accept = start && !busy;

  // Stage A: capture the transaction
  logic            a_vld_q;
  gep_pkg::carry_t a_c_d, a_c_q;
  always_comb begin
    a_c_d        = '0;
    a_c_d.px     = particle_i.pos_x;
    a_c_d.py     = particle_i.pos_y;
    a_c_d.vx     = particle_i.vel_x;
    a_c_d.vy     = particle_i.vel_y;
    a_c_d.dt     = particle_i.time_step;
    a_c_d.frozen = particle_i.particle_mass > gep_pkg::FROZEN_MASS_RAW;
  end

  // Stage B: position step magnitudes
  logic            b_vld_q;
  gep_pkg::carry_t b_c_q;
  logic [31:0]     b_stx_q, b_sty_q;
  logic [47:0]     prod_sx, prod_sy;
  assign prod_sx = abs32(a_c_q.vx) * a_c_q.dt;
  assign prod_sy = abs32(a_c_q.vy) * a_c_q.dt;

  // Stage C: saturated new position
  logic            c_vld_q;
  gep_pkg::carry_t c_c_d, c_c_q;
  always_comb begin
    c_c_d    = b_c_q;
    c_c_d.nx = sat34({{2{b_c_q.px[31]}}, b_c_q.px} +
               (b_c_q.vx[31] ? (34'd0 - {2'b0, b_stx_q}) : {2'b0, b_stx_q}));
    c_c_d.ny = sat34({{2{b_c_q.py[31]}}, b_c_q.py} +
               (b_c_q.vy[31] ? (34'd0 - {2'b0, b_sty_q}) : {2'b0, b_sty_q}));
  end

  // Stage D: offset to attractor, magnitudes and signs
  logic            d_vld_q;
  gep_pkg::carry_t d_c_d, d_c_q;
  logic [32:0]     dx, dy, adx, ady;
  always_comb begin
    dx          = {hole_x_q[31], hole_x_q} - {c_c_q.nx[31], c_c_q.nx};
    dy          = {hole_y_q[31], hole_y_q} - {c_c_q.ny[31], c_c_q.ny};
    adx         = dx[32] ? (33'd0 - dx) : dx;
    ady         = dy[32] ? (33'd0 - dy) : dy;
    d_c_d       = c_c_q;
    d_c_d.neg_x = dx[32];
    d_c_d.neg_y = dy[32];
    d_c_d.ax    = adx[31:0];
    d_c_d.ay    = ady[31:0];
  end

  // Stage E: squares
  logic            e_vld_q;
  gep_pkg::carry_t e_c_q;
  logic [63:0]     e_sqx_q, e_sqy_q;

  // Stage F and iterations: square root and acceleration quotient
  gep_pkg::iter_t  it_q   [gep_pkg::DV_STEPS+1];
  gep_pkg::carry_t it_c_q [gep_pkg::DV_STEPS+1];
  logic            it_vld_q [gep_pkg::DV_STEPS+1];
  gep_pkg::iter_t  f_d;
  logic [64:0]     d2;
  logic [63:0]     num;
  always_comb begin
    d2        = {1'b0, e_sqx_q} + {1'b0, e_sqy_q};
    num       = {attraction_q, 16'd0};
    f_d       = '0;
    f_d.hi    = d2[64];
    f_d.sq_n  = d2[64] ? {1'b0, d2[64:2]} : d2[63:0];
    f_d.den   = {1'b0, d2[64:16]} + gep_pkg::SOFTEN_Q16;
    f_d.dv_rem  = {32'd0, num[63:45]};
    f_d.dv_bits = num[44:0];
  end

  // Front stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q     <= 1'b0;
      b_vld_q     <= 1'b0;
      c_vld_q     <= 1'b0;
      d_vld_q     <= 1'b0;
      e_vld_q     <= 1'b0;
      it_vld_q[0] <= 1'b0;
    end else begin
      a_vld_q     <= accept;
      b_vld_q     <= a_vld_q;
      c_vld_q     <= b_vld_q;
      d_vld_q     <= c_vld_q;
      e_vld_q     <= d_vld_q;
      it_vld_q[0] <= e_vld_q;
    end
  end

  // Front stage payload
  always_ff @(posedge clk_i) begin
    a_c_q     <= a_c_d;
    b_c_q     <= a_c_q;
    b_stx_q   <= prod_sx[47:16];
    b_sty_q   <= prod_sy[47:16];
    c_c_q     <= c_c_d;
    d_c_q     <= d_c_d;
    e_c_q     <= d_c_q;
    e_sqx_q   <= d_c_q.ax * d_c_q.ax;
    e_sqy_q   <= d_c_q.ay * d_c_q.ay;
    it_q[0]   <= f_d;
    it_c_q[0] <= e_c_q;
  end

  // One quotient bit per stage, and one root bit per stage in the first SQ_STEPS stages
  for (genvar k = 0; k < gep_pkg::DV_STEPS; k++) begin : g_iter
    gep_pkg::iter_t nxt;
    logic [34:0]    rs, trial;
    logic [50:0]    rd;
    always_comb begin
      nxt   = it_q[k];
      rs    = {it_q[k].sq_rem[32:0], it_q[k].sq_n[63:62]};
      trial = {1'b0, it_q[k].sq_root, 2'b01};
      if (k < gep_pkg::SQ_STEPS) begin
        nxt.sq_n = {it_q[k].sq_n[61:0], 2'b00};
        if (rs >= trial) begin
          nxt.sq_rem  = rs - trial;
          nxt.sq_root = {it_q[k].sq_root[30:0], 1'b1};
        end else begin
          nxt.sq_rem  = rs;
          nxt.sq_root = {it_q[k].sq_root[30:0], 1'b0};
        end
      end
      rd          = {it_q[k].dv_rem[49:0], it_q[k].dv_bits[44]};
      nxt.dv_bits = {it_q[k].dv_bits[43:0], 1'b0};
      if (rd >= {1'b0, it_q[k].den}) begin
        nxt.dv_rem = rd - {1'b0, it_q[k].den};
        nxt.dv_q   = {it_q[k].dv_q[43:0], 1'b1};
      end else begin
        nxt.dv_rem = rd;
        nxt.dv_q   = {it_q[k].dv_q[43:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) it_vld_q[k+1] <= 1'b0;
      else         it_vld_q[k+1] <= it_vld_q[k];
    end
    always_ff @(posedge clk_i) begin
      it_q[k+1]   <= nxt;
      it_c_q[k+1] <= it_c_q[k];
    end
  end

  // Stage G: distance, force magnitude, capture test, direction divider setup
  gep_pkg::udiv_t  ud_q   [gep_pkg::UX_STEPS+1];
  gep_pkg::carry_t ud_c_q [gep_pkg::UX_STEPS+1];
  logic            ud_vld_q [gep_pkg::UX_STEPS+1];
  gep_pkg::udiv_t  g_d;
  gep_pkg::iter_t  it_l;
  gep_pkg::carry_t c_l;
  logic [60:0]     acc_dt;
  always_comb begin
    it_l         = it_q[gep_pkg::DV_STEPS];
    c_l          = it_c_q[gep_pkg::DV_STEPS];
    acc_dt       = it_l.dv_q * c_l.dt;
    g_d          = '0;
    g_d.span     = it_l.hi ? {it_l.sq_root, 1'b0} : {1'b0, it_l.sq_root};
    g_d.zero     = g_d.span == 33'd0;
    g_d.captured = g_d.span < ({1'b0, hole_radius_q} + gep_pkg::CAPTURE_MARGIN_Q16);
    g_d.mag      = acc_dt[60:16];
    g_d.over_x   = {2'b0, c_l.ax} >= {g_d.span, 1'b0};
    g_d.over_y   = {2'b0, c_l.ay} >= {g_d.span, 1'b0};
    g_d.rx       = {2'b0, c_l.ax[31:1]};
    g_d.ry       = {2'b0, c_l.ay[31:1]};
    g_d.bx       = {c_l.ax[0], 16'd0};
    g_d.by       = {c_l.ay[0], 16'd0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ud_vld_q[0] <= 1'b0;
    else         ud_vld_q[0] <= it_vld_q[gep_pkg::DV_STEPS];
  end
  always_ff @(posedge clk_i) begin
    ud_q[0]   <= g_d;
    ud_c_q[0] <= c_l;
  end

  // One direction bit per stage for both axes
  for (genvar j = 0; j < gep_pkg::UX_STEPS; j++) begin : g_udiv
    gep_pkg::udiv_t nxt;
    logic [33:0]    rx, ry;
    always_comb begin
      nxt    = ud_q[j];
      rx     = {ud_q[j].rx, ud_q[j].bx[16]};
      ry     = {ud_q[j].ry, ud_q[j].by[16]};
      nxt.bx = {ud_q[j].bx[15:0], 1'b0};
      nxt.by = {ud_q[j].by[15:0], 1'b0};
      if (rx >= {1'b0, ud_q[j].span}) begin
        nxt.rx = 33'(rx - {1'b0, ud_q[j].span});
        nxt.qx = {ud_q[j].qx[15:0], 1'b1};
      end else begin
        nxt.rx = rx[32:0];
        nxt.qx = {ud_q[j].qx[15:0], 1'b0};
      end
      if (ry >= {1'b0, ud_q[j].span}) begin
        nxt.ry = 33'(ry - {1'b0, ud_q[j].span});
        nxt.qy = {ud_q[j].qy[15:0], 1'b1};
      end else begin
        nxt.ry = ry[32:0];
        nxt.qy = {ud_q[j].qy[15:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) ud_vld_q[j+1] <= 1'b0;
      else         ud_vld_q[j+1] <= ud_vld_q[j];
    end
    always_ff @(posedge clk_i) begin
      ud_q[j+1]   <= nxt;
      ud_c_q[j+1] <= ud_c_q[j];
    end
  end

  // Stage H: clamp direction, velocity increments
  gep_pkg::udiv_t  u_l;
  logic [16:0]     ux, uy;
  logic [61:0]     dvx_p, dvy_p;
  logic            h_vld_q;
  gep_pkg::carry_t h_c_q;
  logic [45:0]     h_dvx_q, h_dvy_q;
  logic            h_cap_q;
  always_comb begin
    u_l = ud_q[gep_pkg::UX_STEPS];
    if (u_l.zero) begin
      ux = '0;
      uy = '0;
    end else begin
      ux = (u_l.over_x || u_l.qx > gep_pkg::UNIT_ONE) ? gep_pkg::UNIT_ONE : u_l.qx;
      uy = (u_l.over_y || u_l.qy > gep_pkg::UNIT_ONE) ? gep_pkg::UNIT_ONE : u_l.qy;
    end
    dvx_p = u_l.mag * ux;
    dvy_p = u_l.mag * uy;
  end

  // Stage I: saturated velocity and result register
  logic [31:0]        nvx, nvy;
  gep_pkg::part_out_t res_d;
  always_comb begin
    nvx = sat48({{16{h_c_q.vx[31]}}, h_c_q.vx} +
          (h_c_q.neg_x ? (48'd0 - {2'b0, h_dvx_q}) : {2'b0, h_dvx_q}));
    nvy = sat48({{16{h_c_q.vy[31]}}, h_c_q.vy} +
          (h_c_q.neg_y ? (48'd0 - {2'b0, h_dvy_q}) : {2'b0, h_dvy_q}));
    if (h_c_q.frozen) begin
      res_d.new_pos_x = h_c_q.px;
      res_d.new_pos_y = h_c_q.py;
      res_d.new_vel_x = h_c_q.vx;
      res_d.new_vel_y = h_c_q.vy;
      res_d.status    = gep_pkg::ST_FROZEN;
    end else begin
      res_d.new_pos_x = h_c_q.nx;
      res_d.new_pos_y = h_c_q.ny;
      res_d.new_vel_x = nvx;
      res_d.new_vel_y = nvy;
      res_d.status    = h_cap_q ? gep_pkg::ST_CAPTURED : gep_pkg::ST_UPDATED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_vld_q  <= 1'b0;
      strobe_o <= 1'b0;
    end else begin
      h_vld_q  <= ud_vld_q[gep_pkg::UX_STEPS];
      strobe_o <= h_vld_q;
    end
  end
  always_ff @(posedge clk_i) begin
    h_c_q    <= ud_c_q[gep_pkg::UX_STEPS];
    h_dvx_q  <= dvx_p[61:16];
    h_dvy_q  <= dvy_p[61:16];
    h_cap_q  <= u_l.captured;
    result_o <= res_d;
  end

  // Every accepted transaction yields its result after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(gep_pkg::LATENCY) strobe_o)
    else $error("result missing after accept");

  // No result without an accept the fixed latency earlier
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(accept, gep_pkg::LATENCY))
    else $error("result without accept");

  // Zero distance only for a particle sitting on the attractor
  a_zero_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ud_vld_q[0] && ud_q[0].zero) |-> (ud_c_q[0].ax == 32'd0 && ud_c_q[0].ay == 32'd0))
    else $error("zero root for nonzero offset");

endmodule
`default_nettype wire

>>> verif/gravity_euler_particle_step_top_tb.sv
`default_nettype none
module gravity_euler_particle_step_top_tb;

  localparam int unsigned DRAIN_CYCLES = 90;
  localparam int unsigned STALL_LIMIT  = 2000;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start;
  logic               busy;
  gep_pkg::part_in_t  particle_i;
  logic               strobe_o;
  gep_pkg::part_out_t result_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i;
  logic [47:0]        cfg_data_i;

  // Predictor copy of the attractor registers
  logic [31:0] m_hole_x;
  logic [31:0] m_hole_y;
  logic [31:0] m_radius;
  logic [47:0] m_attract;

  gep_pkg::part_out_t step_q[$];
  int unsigned        err_cnt;
  int unsigned        idle_cycles;
  bit                 quiet;

  gravity_euler_particle_step_top dut (.*);

  // Clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Integer square root, floor
  function automatic logic [63:0] isqrt(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n   = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Euler step of one particle
  function automatic gep_pkg::part_out_t euler_step(input gep_pkg::part_in_t p);
    gep_pkg::part_out_t r;
    logic signed [65:0] px, py, vx, vy, nx, ny, dx, dy;
    logic [65:0]        avx, avy, ax, ay, d2, span, den, acc, mag, ux, uy;
    logic [65:0]        stx, sty;
    logic [97:0]        num;
    r = '0;
    if (p.particle_mass > gep_pkg::FROZEN_MASS_RAW) begin
      r.new_pos_x = p.pos_x;
      r.new_pos_y = p.pos_y;
      r.new_vel_x = p.vel_x;
      r.new_vel_y = p.vel_y;
      r.status    = gep_pkg::ST_FROZEN;
      return r;
    end
    px  = 66'(p.pos_x);
    py  = 66'(p.pos_y);
    vx  = 66'(p.vel_x);
    vy  = 66'(p.vel_y);
    avx = (vx < 0) ? -vx : vx;
    avy = (vy < 0) ? -vy : vy;
    stx = (avx * p.time_step) >> 16;
    sty = (avy * p.time_step) >> 16;
    nx  = 66'(clamp32((vx < 0) ? px - $signed(stx) : px + $signed(stx)));
    ny  = 66'(clamp32((vy < 0) ? py - $signed(sty) : py + $signed(sty)));
    dx  = $signed(m_hole_x) - nx;
    dy  = $signed(m_hole_y) - ny;
    ax  = (dx < 0) ? -dx : dx;
    ay  = (dy < 0) ? -dy : dy;
    d2  = ax * ax + ay * ay;
    if (d2[64]) span = {1'b0, isqrt(d2[65:2]), 1'b0};
    else span = {2'b0, isqrt(d2[63:0])};
    den = (d2 >> 16) + 66'd655360;
    num = {50'd0, m_attract} << 16;
    acc = 66'(num / den);
    mag = (acc * p.time_step) >> 16;
    ux  = 0;
    uy  = 0;
    if (span != 0) begin
      ux = (ax << 16) / span;
      uy = (ay << 16) / span;
      if (ux > 66'd65536) ux = 66'd65536;
      if (uy > 66'd65536) uy = 66'd65536;
    end
    ux = (mag * ux) >> 16;
    uy = (mag * uy) >> 16;
    r.new_pos_x = nx[31:0];
    r.new_pos_y = ny[31:0];
    r.new_vel_x = clamp32((dx < 0) ? vx - $signed(ux) : vx + $signed(ux));
    r.new_vel_y = clamp32((dy < 0) ? vy - $signed(uy) : vy + $signed(uy));
    r.status    = (span < {34'd0, m_radius} + 66'd1310720) ? gep_pkg::ST_CAPTURED
                                                         : gep_pkg::ST_UPDATED;
    return r;
  endfunction

  // Idle gap of random length now and then, unless quiet is set
  task automatic maybe_idle();
    int unsigned n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 5);
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Send one particle; start stays high across back-to-back transactions
  task automatic send_particle(input gep_pkg::part_in_t p);
    maybe_idle();
    start      <= 1'b1;
    particle_i <= p;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    step_q = {step_q, euler_step(p)};
  endtask

  // Register write while idle
  task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      gep_pkg::CFG_HOLE_X:      m_hole_x  = val[31:0];
      gep_pkg::CFG_HOLE_Y:      m_hole_y  = val[31:0];
      gep_pkg::CFG_HOLE_RADIUS: m_radius  = val[31:0];
      gep_pkg::CFG_ATTRACTION:  m_attract = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (step_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic gep_pkg::part_in_t rand_particle(input bit near);
    gep_pkg::part_in_t p;
    p.pos_x = $urandom();
    p.pos_y = $urandom();
    p.vel_x = $urandom();
    p.vel_y = $urandom();
    if (near) begin
      p.pos_x = $signed(m_hole_x) + $signed($urandom_range(0, 2000000)) - 1000000;
      p.pos_y = $signed(m_hole_y) + $signed($urandom_range(0, 2000000)) - 1000000;
      p.vel_x = $signed($urandom_range(0, 20000000)) - 10000000;
      p.vel_y = $signed($urandom_range(0, 20000000)) - 10000000;
    end
    p.particle_mass = ($urandom_range(0, 7) == 0) ? 24'($urandom())
                                                  : 24'($urandom_range(0, 256000));
    p.time_step     = 16'($urandom());
    return p;
  endfunction

  function automatic gep_pkg::part_in_t mk(input logic [31:0] x, y, vx, vy,
                                           input logic [23:0] m, input logic [15:0] dt);
    gep_pkg::part_in_t p;
    p.pos_x = x; p.pos_y = y; p.vel_x = vx; p.vel_y = vy;
    p.particle_mass = m; p.time_step = dt;
    return p;
  endfunction

  // Edge values: extremes, frozen boundary, zero distance, saturation
  task automatic test_directed();
    send_particle(mk(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 24'd0, 16'hffff));
    send_particle(mk(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 24'd10, 16'hffff));
    send_particle(mk(32'h1, 32'h2, 32'h3, 32'h4, 24'd256000, 16'd100));
    send_particle(mk(32'h1, 32'h2, 32'h3, 32'h4, 24'd256001, 16'd100));
    send_particle(mk(32'hffffffff, 32'h0, 32'h0, 32'hffffffff, 24'hffffff, 16'hffff));
    send_particle(mk(m_hole_x, m_hole_y, 32'd0, 32'd0, 24'd5, 16'd1000));
    send_particle(mk(m_hole_x, m_hole_y - 32'h10000, 32'd0, 32'h10000, 24'd5, 16'hffff));
    send_particle(mk(m_hole_x + 32'h1e0000, m_hole_y, 32'd0, 32'd0, 24'd5, 16'd0));
    send_particle(mk(m_hole_x + 32'h1e0001, m_hole_y, 32'd0, 32'd0, 24'd5, 16'd0));
    send_particle(mk(32'h0, 32'h0, 32'h12345678, 32'hedcba987, 24'd100, 16'h8000));
  endtask

  task automatic test_attractor(input logic [47:0] a, input int unsigned n);
    write_reg(gep_pkg::CFG_ATTRACTION, a);
    repeat (n) send_particle(rand_particle($urandom_range(0, 2) != 0));
    drain();
  endtask

  // Sweep attractor settings including extremes
  task automatic test_configs();
    write_reg(gep_pkg::CFG_HOLE_RADIUS, 48'hffffffff);
    test_attractor(48'hffffffffffff, 60);
    write_reg(gep_pkg::CFG_HOLE_X, 48'h80000000);
    write_reg(gep_pkg::CFG_HOLE_Y, 48'h7fffffff);
    write_reg(gep_pkg::CFG_HOLE_RADIUS, 48'd0);
    test_attractor(48'd1, 60);
    test_directed();
    drain();
    write_reg(gep_pkg::CFG_HOLE_X, 48'h7fffffff);
    write_reg(gep_pkg::CFG_HOLE_Y, 48'h80000000);
    test_attractor($urandom() * 48'd65536 + $urandom_range(0, 65535), 60);
    write_reg(3'd7, 48'h123456789abc);
  endtask

  task automatic test_random();
    int unsigned k;
    for (k = 0; k < 12; k++) begin
      write_reg(gep_pkg::CFG_HOLE_X, 48'($urandom()));
      write_reg(gep_pkg::CFG_HOLE_Y, 48'($urandom()));
      write_reg(gep_pkg::CFG_HOLE_RADIUS,
                48'($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 4000000)));
      test_attractor({$urandom(), 16'(0)} >> $urandom_range(0, 47) | 48'($urandom()), 50);
    end
    quiet = 1'b1;
    test_attractor(48'h0000ffffffff, 40);
  endtask

  // Result checker
  always @(posedge clk_i) begin
    gep_pkg::part_out_t e;
    if (rst_ni && strobe_o) begin
      if (step_q.size() == 0) begin
        $display("%0t unexpected result %p", $time, result_o);
        err_cnt <= err_cnt + 1;
      end else begin
        e = step_q.pop_front();
        if (result_o !== e) begin
          $display("%0t mismatch expected %p actual %p", $time, e, result_o);
          err_cnt <= err_cnt + 1;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction
  always @(posedge clk_i) begin
    if ((start && !busy) || strobe_o || (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0; start = 1'b0; particle_i = '0;
    cfg_valid_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    err_cnt = 0; idle_cycles = 0; quiet = 1'b0;
    m_hole_x = gep_pkg::HOLE_X_RST; m_hole_y = gep_pkg::HOLE_Y_RST;
    m_radius = gep_pkg::HOLE_RADIUS_RST; m_attract = gep_pkg::ATTRACTION_RST;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    drain();
    test_configs();
    test_random();
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && step_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
